### design/sorted_list_engine_defines.svh
// Assertion macros for the sorted list engine.
// Included by the top level; no other dependencies.
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define SLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SLE_ASSERT_IMPL(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) trig |=> prop) \
        else $error(msg);
`else
`define SLE_ASSERT(label, prop, msg)
`define SLE_ASSERT_IMPL(label, trig, prop, msg)
`endif
`endif

### design/sle_pkg.sv
// Shared types and constants for the sorted list engine.
// No dependencies; used by sle_cell and sorted_list_engine.
`default_nettype none
package sle_pkg;
    localparam int SLE_DEPTH = 16;

    typedef enum logic [2:0] {
        FUNC_INSERT       = 3'd0,
        FUNC_REMOVE       = 3'd1,
        FUNC_SEARCH       = 3'd2,
        FUNC_REMOVE_FIRST = 3'd3,
        FUNC_CLEAR        = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SHIFT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] smallest;
        logic [4:0]         count;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        t_cell_op           op;
        logic               en;
        logic signed [31:0] key;
    } t_cell_ctrl;
endpackage
`default_nettype wire

### design/sle_cell.sv
// One storage cell of the sorted list chain.
// Depends on sle_pkg; instantiated DEPTH times by sorted_list_engine.
`default_nettype none
module sle_cell
    import sle_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic               i_valid,
    input  wire logic               i_left_p,
    input  wire logic signed [31:0] i_left_val,
    input  wire logic signed [31:0] i_right_val,
    output logic                    o_p,
    output logic                    o_eq,
    output logic signed [31:0]      o_val,
    output logic signed [31:0]      o_next_val
);
    logic signed [31:0] r_val;
    logic signed [31:0] n_val;
    logic               ge;

    assign ge   = i_valid && (r_val >= i_ctrl.key);
    assign o_p  = !i_valid || ge;
    assign o_eq = i_valid && (r_val == i_ctrl.key);

    always_comb begin
        unique case (i_ctrl.op)
            CELL_INSERT: n_val = o_p ? (i_left_p ? i_left_val : i_ctrl.key) : r_val;
            CELL_REMOVE: n_val = ge ? i_right_val : r_val;
            CELL_SHIFT:  n_val = i_right_val;
            default:     n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_val <= n_val;
        end
    end

    assign o_val      = r_val;
    assign o_next_val = n_val;
endmodule
`default_nettype wire

### design/sorted_list_engine.sv
// Sorted list engine: keeps up to DEPTH signed 32-bit keys in ascending order.
// Input beats carry func and key; each accepted beat yields one output beat.
// Insert, remove, search, remove_first and clear act on a chain of cells
// that each hold one entry and compare it with the key in parallel.
// An accepted beat updates every cell in the same cycle, and its result shows on
// o_out_valid in the next cycle; the block accepts one beat
// per cycle while the result register is free or being drained.
// The result register is the only output stage: when it holds a beat and the
// receiver stalls, o_in_stall rises and the cell chain holds its contents.
// Synchronous reset empties the store and drops any pending result; entry
// values are not cleared, since only the first count entries are ever read.
// Outputs report the store after each operation: status, found, smallest
// entry (zero when empty), count modulo 32 and an empty flag.
// Depends on sle_pkg, sle_cell and sorted_list_engine_defines.svh.
`default_nettype none
`include "sorted_list_engine_defines.svh"
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int DEPTH = SLE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    t_out_item          r_out_data;
    t_out_item          n_out_data;
    logic               accept;
    logic               found;
    logic               full;
    logic               empty;
    t_cell_ctrl         ctrl;
    t_status            status;
    logic [DEPTH-1:0]   cell_p;
    logic [DEPTH-1:0]   cell_eq;
    logic signed [31:0] cell_val  [DEPTH];
    logic signed [31:0] cell_next [DEPTH];
    logic [31:0]        count_ext;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign found      = |cell_eq;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        ctrl.key = i_in_data.key;
        ctrl.en  = accept;
        ctrl.op  = CELL_HOLD;
        status   = ST_OK;
        n_count  = r_count;
        unique case (i_in_data.func)
            FUNC_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.op = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (found) begin
                    ctrl.op = CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end else begin
                    status = ST_NOT_FOUND;
                end
            end
            FUNC_SEARCH: begin
                if (!found) begin
                    status = ST_NOT_FOUND;
                end
            end
            FUNC_REMOVE_FIRST: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctrl.op = CELL_SHIFT;
                    n_count = r_count - 1'b1;
                end
            end
            FUNC_CLEAR: n_count = '0;
            default:    n_count = r_count;
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic               left_p;
        logic signed [31:0] left_val;
        logic signed [31:0] right_val;
        if (g == 0) begin : g_first
            assign left_p   = 1'b0;
            assign left_val = i_in_data.key;
        end else begin : g_mid
            assign left_p   = cell_p[g-1];
            assign left_val = cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = cell_val[g+1];
        end
        sle_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_valid     (CW'(g) < r_count),
            .i_left_p    (left_p),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_p         (cell_p[g]),
            .o_eq        (cell_eq[g]),
            .o_val       (cell_val[g]),
            .o_next_val  (cell_next[g])
        );
    end

    assign count_ext = 32'(n_count);

    always_comb begin
        n_out_data.status   = status;
        n_out_data.found    = found && (i_in_data.func == FUNC_SEARCH ||
                                        i_in_data.func == FUNC_REMOVE);
        n_out_data.smallest = (n_count != '0) ? cell_next[0] : '0;
        n_out_data.count    = count_ext[4:0];
        n_out_data.is_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SLE_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "count exceeds depth")
    `SLE_ASSERT_IMPL(a_full_insert, accept && i_in_data.func == FUNC_INSERT && full, r_count == $past(r_count), "insert into full store changed count")
    `SLE_ASSERT(a_empty_flag, r_out_valid |-> (r_out_data.is_empty == (r_count == '0)), "empty flag disagrees with count")
    `SLE_ASSERT(a_sorted_head, r_count >= CW'(2) |-> cell_val[0] <= cell_val[1], "first two entries out of order")
endmodule
`default_nettype wire
